/* rtl/chbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  localparam int unsigned SizeLineMax = 31;
  localparam int unsigned SizeBits    = 32;
  localparam int unsigned HexBits     = 4;
  localparam int unsigned LineCntW    = $clog2(SizeLineMax + 1);

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  typedef enum logic [2:0] {
    PH_LINE    = 3'd0,
    PH_LINE_CR = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_DONE    = 3'd5,
    PH_FAIL    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    phase_e                phase;
    logic [SizeBits-1:0]   size;
    logic [LineCntW-1:0]   cnt;
    logic                  hex_act;
    logic                  digit_seen;
    logic                  ovf;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data_byte;
    logic       data;
    status_e    status;
  } parse_result_t;

  typedef struct packed {
    logic               ok;
    logic [HexBits-1:0] val;
  } hex_t;

  localparam parse_state_t ResetState = '{
    phase:      PH_LINE,
    size:       '0,
    cnt:        '0,
    hex_act:    1'b1,
    digit_seen: 1'b0,
    ovf:        1'b0
  };

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    begin
      h.ok  = 1'b1;
      h.val = c[HexBits-1:0];
      if (c inside {[8'h30:8'h39]}) begin
        h.val = c[HexBits-1:0];
      end else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]})) begin
        h.val = HexBits'(c[HexBits-1:0] + HexBits'(9));
      end else begin
        h.ok = 1'b0;
      end
      return h;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/chbd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbd_parser
// Framing state and the per-word next-state and result logic.
// ----------------------------------------------------------------------------
module chbd_parser (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        step_i,
  input  wire  [7:0]                 byte_i,
  input  wire                        last_i,
  output chbd_pkg::parse_result_t    res_o
);

  chbd_pkg::parse_state_t st_q, st_d, nx;
  chbd_pkg::hex_t         hx;
  logic                   line_full;
  logic                   line_near;
  logic                   was_end;
  logic                   is_end;
  logic                   data;

  assign hx        = chbd_pkg::hex_decode(byte_i);
  assign line_full = st_q.cnt >= chbd_pkg::LineCntW'(chbd_pkg::SizeLineMax);
  assign line_near = st_q.cnt == chbd_pkg::LineCntW'(chbd_pkg::SizeLineMax - 1);

  always_comb begin
    nx   = st_q;
    data = 1'b0;
    case (st_q.phase)
      chbd_pkg::PH_LINE: begin
        if (byte_i == chbd_pkg::CharCr) begin
          nx.phase = chbd_pkg::PH_LINE_CR;
        end else if (line_full) begin
          nx.phase = chbd_pkg::PH_FAIL;
        end else begin
          nx.cnt = st_q.cnt + 1'b1;
          if (st_q.hex_act) begin
            if (!hx.ok) begin
              nx.hex_act = 1'b0;
            end else begin
              nx.digit_seen = 1'b1;
              if (st_q.size[chbd_pkg::SizeBits-1 -: chbd_pkg::HexBits] != '0) begin
                nx.ovf = 1'b1;
              end
              nx.size = {st_q.size[chbd_pkg::SizeBits-chbd_pkg::HexBits-1:0], hx.val};
            end
          end
        end
      end
      chbd_pkg::PH_LINE_CR: begin
        if (byte_i == chbd_pkg::CharLf) begin
          if ((st_q.cnt == '0) || !st_q.digit_seen || st_q.ovf) begin
            nx.phase = chbd_pkg::PH_FAIL;
          end else if (st_q.size == '0) begin
            nx.phase = chbd_pkg::PH_DONE;
          end else begin
            nx.phase = chbd_pkg::PH_DATA;
          end
        end else if (byte_i == chbd_pkg::CharCr) begin
          // lone cr counts as line text
          if (line_full) begin
            nx.phase = chbd_pkg::PH_FAIL;
          end else begin
            nx.cnt     = st_q.cnt + 1'b1;
            nx.hex_act = 1'b0;
          end
        end else begin
          // lone cr plus this character both count as line text
          if (line_full || line_near) begin
            nx.phase = chbd_pkg::PH_FAIL;
          end else begin
            nx.phase   = chbd_pkg::PH_LINE;
            nx.cnt     = st_q.cnt + chbd_pkg::LineCntW'(2);
            nx.hex_act = 1'b0;
          end
        end
      end
      chbd_pkg::PH_DATA: begin
        data    = 1'b1;
        nx.size = st_q.size - 1'b1;
        if (st_q.size == chbd_pkg::SizeBits'(1)) begin
          nx.phase = chbd_pkg::PH_DATA_CR;
        end
      end
      chbd_pkg::PH_DATA_CR: begin
        nx.phase = (byte_i == chbd_pkg::CharCr) ? chbd_pkg::PH_DATA_LF : chbd_pkg::PH_FAIL;
      end
      chbd_pkg::PH_DATA_LF: begin
        if (byte_i == chbd_pkg::CharLf) begin
          nx = chbd_pkg::ResetState;
        end else begin
          nx.phase = chbd_pkg::PH_FAIL;
        end
      end
      chbd_pkg::PH_DONE: begin
        nx.phase = chbd_pkg::PH_DONE;
      end
      default: begin
        nx.phase = chbd_pkg::PH_FAIL;
      end
    endcase
    if (last_i && (nx.phase != chbd_pkg::PH_DONE)) begin
      nx.phase = chbd_pkg::PH_FAIL;
    end
  end

  always_comb begin
    was_end = !((st_q.phase == chbd_pkg::PH_LINE) || (st_q.phase == chbd_pkg::PH_LINE_CR) ||
                (st_q.phase == chbd_pkg::PH_DATA) || (st_q.phase == chbd_pkg::PH_DATA_CR) ||
                (st_q.phase == chbd_pkg::PH_DATA_LF));
    is_end  = (nx.phase == chbd_pkg::PH_DONE) || (nx.phase == chbd_pkg::PH_FAIL);

    res_o.emit      = data || (is_end && !was_end);
    res_o.data      = data;
    res_o.data_byte = data ? byte_i : 8'h00;
    res_o.status    = chbd_pkg::ST_RUN;
    if (!was_end && (nx.phase == chbd_pkg::PH_DONE)) begin
      res_o.status = chbd_pkg::ST_DONE;
    end
    if (!was_end && (nx.phase == chbd_pkg::PH_FAIL)) begin
      res_o.status = chbd_pkg::ST_ERR;
    end
  end

  // back to reset after the end-of-body word
  assign st_d = last_i ? chbd_pkg::ResetState : nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= chbd_pkg::ResetState;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/chunked_body_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_body_decoder_unit
// Strips chunked transfer framing from a body stream, one byte per word.
// ----------------------------------------------------------------------------
// datapath: input register, then the parser step, then the result register
// throughput: one input word per cycle unless the output is back-pressured,
//   set by the input register feeding the parser step into the result register
// reset: asynchronous, clears both stage valids and the parser state; the
//   parser also returns to its start state after every end-of-body word
module chunked_body_decoder_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] in_byte_i,
  input  wire        end_of_body_i,
  output logic       res_valid_o,
  input  wire        res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic [1:0] status_o
);

  logic                    s1_vld_q;
  logic [7:0]              s1_byte_q;
  logic                    s1_last_q;
  logic                    res_vld_q;
  logic [7:0]              res_byte_q;
  logic                    res_data_q;
  chbd_pkg::status_e       res_status_q;
  logic                    advance;
  logic                    in_take;
  chbd_pkg::parse_result_t res;

  assign advance    = s1_vld_q && (!res_vld_q || !res_stall_i);
  assign in_stall_o = s1_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_take || advance) begin
      s1_vld_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= end_of_body_i;
    end
  end

  chbd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= res.emit;
    end else if (res_vld_q && !res_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      res_byte_q   <= res.data_byte;
      res_data_q   <= res.data;
      res_status_q <= res.status;
    end
  end

  assign res_valid_o = res_vld_q;
  assign out_byte_o  = res_byte_q;
  assign out_valid_o = res_data_q;
  assign status_o    = res_status_q;

`ifndef SYNTHESIS
  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (res_valid_o && res_stall_i))
    else $error("input stalled without output backpressure");

  a_payload_never_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_valid_o) |-> (status_o != chbd_pkg::ST_DONE))
    else $error("payload word reported with complete status");

  a_framing_result_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !out_valid_o) |-> ((status_o != chbd_pkg::ST_RUN) && (out_byte_o == 8'h00)))
    else $error("non-payload result without final status");
`endif

endmodule
`default_nettype wire
